// ===== rtl/ppp_pkg.sv =====
// Shared types and constants for the perspective point projection block.
`default_nettype none

package ppp_pkg;

   localparam int COORD_W     = 32;
   localparam int SIZE_W      = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int COEF_IDX_W  = 4;
   localparam int ROW_W       = 2;
   localparam int Q_BITS      = 33;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

   localparam logic [ROW_W-1:0] ROW_X = 2'd0;
   localparam logic [ROW_W-1:0] ROW_Y = 2'd1;
   localparam logic [ROW_W-1:0] ROW_W_CLIP = 2'd3;
   localparam logic [ROW_W-1:0] COL_T = 2'd3;
   localparam logic [ROW_W-1:0] COL_Z = 2'd2;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = 14'd1920;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = 14'd1080;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_MUL      = 11'b000_0000_0010,
      ST_ACC      = 11'b000_0000_0100,
      ST_TRANS    = 11'b000_0000_1000,
      ST_PREP     = 11'b000_0001_0000,
      ST_SMUL_LO  = 11'b000_0010_0000,
      ST_SMUL_HI  = 11'b000_0100_0000,
      ST_SCOMB    = 11'b000_1000_0000,
      ST_DIV_INIT = 11'b001_0000_0000,
      ST_DIV_STEP = 11'b010_0000_0000,
      ST_DIV_DONE = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/perspective_point_projection_top.sv =====
// Perspective point projection: matrix store, shared multiplier and serial divider.
// Load word: taken while idle, no result; the next word may follow at once.
// Project word: result after 13 passes through the shared 33x33 multiplier and two
// 33-step restoring divisions; an overflowing quotient skips the 33 steps.
// Rejected point (clip w at or below threshold): result after the clip row. A held result
// stalls the block; it is idle again with the result. Reset: zero matrix, 1920 x 1080.
`default_nettype none

module perspective_point_projection_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_mode,
   input  wire logic [ppp_pkg::COEF_IDX_W-1:0]     req_coef_index,
   input  wire logic signed [ppp_pkg::COORD_W-1:0] req_coef_value,
   input  wire logic signed [ppp_pkg::COORD_W-1:0] req_world_x,
   input  wire logic signed [ppp_pkg::COORD_W-1:0] req_world_y,
   input  wire logic signed [ppp_pkg::COORD_W-1:0] req_world_z,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_in_front,
   output logic signed [ppp_pkg::COORD_W-1:0]      rsp_screen_x,
   output logic signed [ppp_pkg::COORD_W-1:0]      rsp_screen_y,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ppp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ppp_pkg::SIZE_W-1:0]         csr_wdata
);

   import ppp_pkg::*;

   localparam int SUM_W  = 65 - FRAC_BITS;
   localparam int DW     = SUM_W;
   localparam int PS_W   = 79 - FRAC_BITS;
   localparam int LO_W   = 32 + SIZE_W;
   localparam int NUM_W  = PS_W + FRAC_BITS;
   localparam int HI_W   = NUM_W - Q_BITS;
   localparam int CMP_W  = ((HI_W > DW) ? HI_W : DW) + 1;
   localparam int CNT_W  = $clog2(Q_BITS);
   localparam int PROD_W = 66;
   localparam logic signed [SUM_W-1:0] THRESH = SUM_W'((64'd1 << FRAC_BITS) / 1000);

   state_type state_ff, state_in;

   logic [COORD_W-1:0] matrix_ff [16];
   logic [SIZE_W-1:0]  width_ff, width_in, height_ff, height_in;

   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ROW_W-1:0]          row_ff, row_in, col_ff, col_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in, w_ff, w_in, sx_ff, sx_in, sy_ff, sy_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]          m_ff, m_in;
   logic                      neg_ff, neg_in, side_ff, side_in;
   logic [PS_W-1:0]           ps_ff, ps_in;
   logic [DW-1:0]             rem_ff, rem_in;
   logic [Q_BITS-1:0]         low_ff, low_in, q_ff, q_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [COORD_W-1:0] rx_ff, rx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_in_front_ff, rsp_in_front_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic signed [32:0]        mul_a, mul_b;
   logic signed [PROD_W-1:0]  mul_p, prod_shr;
   logic [COORD_W-1:0]        coef_sel;
   logic signed [COORD_W-1:0] coord_sel;
   logic signed [SUM_W-1:0]   sum_t;
   logic signed [SUM_W:0]     num_t;
   logic [SIZE_W-1:0]         scale_sel;
   logic [DW-1:0]             den;
   logic [NUM_W-1:0]          num_w;
   logic [CMP_W-1:0]          hi_ext, den_ext;
   logic [DW:0]               trial;
   logic                      trial_ge;
   logic signed [COORD_W-1:0] div_res;
   logic                      out_free, req_fire, load_wr;

   function automatic logic signed [COORD_W-1:0] sat_q(input logic [Q_BITS-1:0] q,
                                                       input logic neg);
      logic [Q_BITS-1:0] nq;
      nq = ~q + Q_BITS'(1);
      if (!neg) begin
         sat_q = (q > Q_BITS'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[COORD_W-1:0];
      end else begin
         sat_q = (q > Q_BITS'(33'h0_8000_0000)) ? 32'sh8000_0000 : nq[COORD_W-1:0];
      end
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign load_wr   = req_fire && (req_mode == MODE_LOAD);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_front = rsp_in_front_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;

   assign coef_sel  = (state_ff == ST_TRANS) ? matrix_ff[{row_ff, COL_T}]
                                             : matrix_ff[{row_ff, col_ff}];
   assign scale_sel = side_ff ? height_ff : width_ff;
   assign prod_shr  = prod_ff >>> FRAC_BITS;
   assign sum_t     = acc_ff + SUM_W'($signed(coef_sel));
   assign num_t     = side_ff ? ((SUM_W+1)'(w_ff) - (SUM_W+1)'(sy_ff))
                              : ((SUM_W+1)'(sx_ff) + (SUM_W+1)'(w_ff));
   assign den       = {w_ff[SUM_W-2:0], 1'b0};
   assign num_w     = {ps_ff, {FRAC_BITS{1'b0}}};
   assign hi_ext    = CMP_W'(num_w[NUM_W-1:Q_BITS]);
   assign den_ext   = CMP_W'(den);
   assign trial     = {rem_ff, low_ff[Q_BITS-1]};
   assign trial_ge  = trial >= {1'b0, den};
   assign div_res   = sat_q(q_ff, neg_ff);

   always_comb begin
      case (col_ff)
         2'd0:    coord_sel = x_ff;
         2'd1:    coord_sel = y_ff;
         default: coord_sel = z_ff;
      endcase
   end

   always_comb begin
      mul_a = 33'($signed(coef_sel));
      mul_b = 33'(coord_sel);
      if (state_ff == ST_SMUL_LO) begin
         mul_a = {1'b0, m_ff[31:0]};
         mul_b = 33'({1'b0, scale_sel});
      end else if (state_ff == ST_SMUL_HI) begin
         mul_a = 33'({1'b0, m_ff[SUM_W-1:32]});
         mul_b = 33'({1'b0, scale_sel});
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_in  = csr_wdata;
            REG_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      z_in            = z_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      acc_in          = acc_ff;
      w_in            = w_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      prod_in         = prod_ff;
      m_in            = m_ff;
      neg_in          = neg_ff;
      side_in         = side_ff;
      ps_in           = ps_ff;
      rem_in          = rem_ff;
      low_in          = low_ff;
      q_in            = q_ff;
      cnt_in          = cnt_ff;
      rx_in           = rx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in_front_in = rsp_in_front_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_mode == MODE_PROJECT) begin
               x_in     = req_world_x;
               y_in     = req_world_y;
               z_in     = req_world_z;
               row_in   = ROW_W_CLIP;
               col_in   = '0;
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + $signed(prod_shr[SUM_W-1:0]);
            if (col_ff == COL_Z) begin
               state_in = ST_TRANS;
            end else begin
               col_in   = col_ff + ROW_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_TRANS: begin
            col_in = '0;
            acc_in = '0;
            case (row_ff)
               ROW_W_CLIP: begin
                  w_in = sum_t;
                  if (sum_t <= THRESH) begin
                     if (out_free) begin
                        rsp_valid_in    = 1'b1;
                        rsp_in_front_in = 1'b0;
                        rsp_x_in        = '0;
                        rsp_y_in        = '0;
                        state_in        = ST_IDLE;
                     end else begin
                        acc_in = acc_ff;
                     end
                  end else begin
                     row_in   = ROW_X;
                     state_in = ST_MUL;
                  end
               end
               ROW_X: begin
                  sx_in    = sum_t;
                  row_in   = ROW_Y;
                  state_in = ST_MUL;
               end
               default: begin
                  sy_in    = sum_t;
                  side_in  = 1'b0;
                  state_in = ST_PREP;
               end
            endcase
         end
         ST_PREP: begin
            neg_in   = num_t[SUM_W];
            m_in     = num_t[SUM_W] ? SUM_W'(-num_t) : num_t[SUM_W-1:0];
            state_in = ST_SMUL_LO;
         end
         ST_SMUL_LO: begin
            prod_in  = mul_p;
            state_in = ST_SMUL_HI;
         end
         ST_SMUL_HI: begin
            ps_in    = PS_W'(prod_ff[LO_W-1:0]);
            prod_in  = mul_p;
            state_in = ST_SCOMB;
         end
         ST_SCOMB: begin
            ps_in    = ps_ff + {prod_ff[PS_W-33:0], 32'b0};
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cnt_in = '0;
            q_in   = '0;
            if (hi_ext >= den_ext) begin
               q_in     = '1;
               state_in = ST_DIV_DONE;
            end else begin
               rem_in   = hi_ext[DW-1:0];
               low_in   = num_w[Q_BITS-1:0];
               state_in = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            rem_in = trial_ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
            low_in = {low_ff[Q_BITS-2:0], 1'b0};
            q_in   = {q_ff[Q_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_BITS - 1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            if (!side_ff) begin
               rx_in    = div_res;
               side_in  = 1'b1;
               state_in = ST_PREP;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in_front_in = 1'b1;
               rsp_x_in        = rx_ff;
               rsp_y_in        = div_res;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= RESET_WIDTH;
         height_ff    <= RESET_HEIGHT;
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         if (load_wr) begin
            matrix_ff[req_coef_index] <= req_coef_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      y_ff            <= y_in;
      z_ff            <= z_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      acc_ff          <= acc_in;
      w_ff            <= w_in;
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      prod_ff         <= prod_in;
      m_ff            <= m_in;
      neg_ff          <= neg_in;
      side_ff         <= side_in;
      ps_ff           <= ps_in;
      rem_ff          <= rem_in;
      low_ff          <= low_in;
      q_ff            <= q_in;
      cnt_ff          <= cnt_in;
      rx_ff           <= rx_in;
      rsp_in_front_ff <= rsp_in_front_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
   end

endmodule

`default_nettype wire

// ===== tb/ppp_tb_pkg.sv =====
// Scoreboard for the projection testbench: matrix and screen-size shadow, pixel predictor, checker.
package ppp_tb_pkg;
   import ppp_pkg::*;

   localparam int    FRAC_BITS = 16;
   localparam longint CLIP_MIN = (longint'(1) << FRAC_BITS) / 1000;
   localparam logic [SIZE_W-1:0] POWER_ON_WIDTH  = 14'd1920;
   localparam logic [SIZE_W-1:0] POWER_ON_HEIGHT = 14'd1080;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic                      in_front;
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
   } pixel_type;

   class projection_checker_type;
      logic signed [COORD_W-1:0] coefs [16];
      logic [SIZE_W-1:0]         screen_w;
      logic [SIZE_W-1:0]         screen_h;
      pixel_type                 expected_pixels [$];
      int unsigned               loads;
      int unsigned               projections;
      int unsigned               visible;
      int unsigned               checked;
      int unsigned               mismatches;

      function new();
         foreach (coefs[i]) coefs[i] = '0;
         screen_w    = POWER_ON_WIDTH;
         screen_h    = POWER_ON_HEIGHT;
         loads       = 0;
         projections = 0;
         visible     = 0;
         checked     = 0;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [SIZE_W-1:0] data);
         if (index == REG_SCREEN_WIDTH) screen_w = data;
         else if (index == REG_SCREEN_HEIGHT) screen_h = data;
      endfunction

      function longint row_dot(int unsigned row, longint x, longint y, longint z);
         longint acc;
         acc  = (longint'(coefs[row*4])     * x) >>> FRAC_BITS;
         acc += (longint'(coefs[row*4 + 1]) * y) >>> FRAC_BITS;
         acc += (longint'(coefs[row*4 + 2]) * z) >>> FRAC_BITS;
         acc += longint'(coefs[row*4 + 3]);
         return acc;
      endfunction

      // num * scale / den in fixed point, truncated toward zero, saturated to 32 bits
      function logic signed [COORD_W-1:0] scale_div(longint num, logic [SIZE_W-1:0] scale,
                                                    longint den);
         logic [127:0] mag;
         logic [127:0] quot;
         if (num < 0) mag = 128'(-num);
         else mag = 128'(num);
         mag  = (mag * 128'(scale)) << FRAC_BITS;
         quot = mag / 128'(den);
         if (num >= 0) begin
            if (quot > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
            return quot[31:0];
         end
         if (quot > 128'h8000_0000) return 32'sh8000_0000;
         return -quot[31:0];
      endfunction

      function void note_word(logic mode, logic [COEF_IDX_W-1:0] idx,
                              logic signed [COORD_W-1:0] coef,
                              logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z);
         pixel_type px;
         longint w;
         longint sx;
         longint sy;
         if (mode == MODE_LOAD) begin
            coefs[idx] = coef;
            loads++;
            return;
         end
         projections++;
         w = row_dot(ROW_W_CLIP, x, y, z);
         if (w <= CLIP_MIN) begin
            px.in_front = 1'b0;
            px.screen_x = '0;
            px.screen_y = '0;
         end else begin
            sx = row_dot(ROW_X, x, y, z);
            sy = row_dot(ROW_Y, x, y, z);
            px.in_front = 1'b1;
            px.screen_x = scale_div(sx + w, screen_w, 2 * w);
            px.screen_y = scale_div(w - sy, screen_h, 2 * w);
            visible++;
         end
         expected_pixels = {expected_pixels, px};
      endfunction

      function void check_result(logic in_front, logic signed [COORD_W-1:0] screen_x,
                                 logic signed [COORD_W-1:0] screen_y);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected result word: in_front=%0d x=%0d y=%0d",
                        in_front, screen_x, screen_y);
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (want.in_front !== in_front || want.screen_x !== screen_x ||
             want.screen_y !== screen_y) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"Mismatch on result %0d: expected in_front=%0d x=%0d y=%0d, ",
                         "got in_front=%0d x=%0d y=%0d"},
                        checked, want.in_front, want.screen_x, want.screen_y,
                        in_front, screen_x, screen_y);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for perspective_point_projection_top: clock, reset, drivers and watchdog.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ppp_pkg::*;
   import ppp_tb_pkg::*;

   localparam int GAP_MAX        = 17;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_WORDS    = 112;
   localparam int WILD_PHASE     = 5;
   localparam int STALL_PHASE    = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;
   localparam logic signed [COORD_W-1:0] ONE = 32'sh0001_0000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = MODE_LOAD;
   logic [COEF_IDX_W-1:0]        req_coef_index = '0;
   logic signed [COORD_W-1:0]    req_coef_value = '0;
   logic signed [COORD_W-1:0]    req_world_x = '0;
   logic signed [COORD_W-1:0]    req_world_y = '0;
   logic signed [COORD_W-1:0]    req_world_z = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_in_front;
   logic signed [COORD_W-1:0]    rsp_screen_x;
   logic signed [COORD_W-1:0]    rsp_screen_y;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [SIZE_W-1:0]            csr_wdata = '0;

   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit stall_rsp_request = 1'b0;
   bit stall_rsp_done = 1'b0;
   int quiet_cycles = 0;

   projection_checker_type sb;

   perspective_point_projection_top #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .req_world_x(req_world_x),
      .req_world_y(req_world_y),
      .req_world_z(req_world_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_in_front(rsp_in_front),
      .rsp_screen_x(rsp_screen_x),
      .rsp_screen_y(rsp_screen_y),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int rand_span(int unsigned span);
      return int'($urandom_range(0, 2 * span)) - int'(span);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return rand_span(1 << 22);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coef(logic [COEF_IDX_W-1:0] idx,
                                                           bit wild);
      if (wild) return $urandom;
      if (idx == {ROW_W_CLIP, COL_T}) return ONE * int'($urandom_range(1, 64));
      if (idx[3:2] == ROW_W_CLIP) return rand_span(1 << 14);
      if ($urandom_range(0, 9) == 0) return $urandom;
      if (idx[1:0] == COL_T) return rand_span(1 << 22);
      if ($urandom_range(0, 4) == 0) return '0;
      return rand_span(1 << 18);
   endfunction

   task automatic send_word(input logic mode, input logic [COEF_IDX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] coef,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_coef_index <= idx;
      req_coef_value <= coef;
      req_world_x    <= x;
      req_world_y    <= y;
      req_world_z    <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(mode, idx, coef, x, y, z);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // hold the input side until every pending word has returned and the pipe is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : result_sink
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (stall_rsp_request && !stall_rsp_done) begin
            stall_rsp_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_in_front, rsp_screen_x, rsp_screen_y);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic signed [COORD_W-1:0] coef;
      logic [COEF_IDX_W-1:0]     idx;
      logic signed [COORD_W-1:0] probes [9][3];
      bit                        wild;
      probes = '{
         '{32'sd0, 32'sd0, ONE},
         '{32'sd0, 32'sd0, 32'sd0},
         '{32'sd0, 32'sd0, 32'sd65},
         '{32'sd0, 32'sd0, 32'sd66},
         '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd66},
         '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
         '{ONE, -ONE, 32'sh8000_0000},
         '{-ONE, ONE, ONE},
         '{ONE >>> 1, -(ONE >>> 1), ONE <<< 1}
      };
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // w = z, x and y pass through; row 2 is unused and carries the coefficient extremes
      for (int i = 0; i < 16; i++) begin
         case (i)
            0, 5, 14: coef = ONE;
            8:        coef = 32'sh8000_0000;
            9:        coef = 32'sh7FFF_FFFF;
            10:       coef = -32'sd1;
            default:  coef = '0;
         endcase
         send_word(MODE_LOAD, 4'(i), coef, $urandom, $urandom, $urandom);
      end
      foreach (probes[p])
         send_word(MODE_PROJECT, 4'($urandom), $urandom,
                   probes[p][0], probes[p][1], probes[p][2]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         wild = (phase == WILD_PHASE);
         case (phase)
            0: begin
               write_reg(REG_SCREEN_WIDTH, 14'd1);
               write_reg(REG_SCREEN_HEIGHT, 14'd1);
            end
            1: begin
               write_reg(REG_SCREEN_WIDTH, 14'd8192);
               write_reg(REG_SCREEN_HEIGHT, 14'd8192);
            end
            2: begin
               write_reg(REG_SCREEN_WIDTH, 14'd0);
               write_reg(REG_SCREEN_HEIGHT, 14'd0);
            end
            3: begin
               write_reg(REG_SCREEN_WIDTH, 14'd16383);
               write_reg(REG_SCREEN_HEIGHT, 14'd16383);
            end
            4: begin
               write_reg(REG_SCREEN_WIDTH, 14'd640);
               write_reg(REG_SCREEN_HEIGHT, 14'd480);
            end
            5: begin
               write_reg(REG_SCREEN_WIDTH, 14'($urandom));
               write_reg(REG_SCREEN_HEIGHT, 14'($urandom));
               write_reg(REG_SPARE_A, 14'($urandom));
               write_reg(REG_SPARE_B, 14'($urandom));
            end
            6: begin
               write_reg(REG_SCREEN_WIDTH, 14'($urandom_range(1, 8192)));
               write_reg(REG_SCREEN_HEIGHT, 14'($urandom_range(1, 8192)));
            end
            default: begin
               write_reg(REG_SPARE_B, 14'h3FFF);
               write_reg(REG_SCREEN_WIDTH, 14'd1920);
               write_reg(REG_SPARE_A, 14'h0000);
               write_reg(REG_SCREEN_HEIGHT, 14'd1080);
            end
         endcase

         for (int i = 0; i < 16; i++)
            send_word(MODE_LOAD, 4'(i), pick_coef(4'(i), wild),
                      pick_coord(), pick_coord(), pick_coord());

         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (phase == STALL_PHASE && n == 20) stall_rsp_request = 1'b1;
            if ($urandom_range(0, 99) < 8) begin
               idx = 4'($urandom);
               send_word(MODE_LOAD, idx, pick_coef(idx, wild),
                         pick_coord(), pick_coord(), pick_coord());
            end else begin
               send_word(MODE_PROJECT, 4'($urandom), $urandom,
                         pick_coord(), pick_coord(), pick_coord());
            end
         end
      end
      drain();

      $display("Covered %0d coefficient loads and %0d projections (%0d in front, %0d rejected)",
               sb.loads, sb.projections, sb.visible, sb.projections - sb.visible);
      $display("over %0d screen settings; %0d result words checked, %0d mismatches.",
               NUM_PHASES + 1, sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ppp_pkg.sv
rtl/perspective_point_projection_top.sv
tb/ppp_tb_pkg.sv
tb/tb_top.sv
